// ----- rtl/scmap_pkg.sv -----
// shared constants and types for the stick calibrate and map block
package scmap_pkg;

	localparam int CHANNELS     = 4;
	localparam int SAMPLE_BITS  = 12;
	localparam int TRIM_BITS    = 9;
	localparam int OUT_BITS     = 12;
	localparam int CH_BITS      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int CFG_IDX_BITS = $clog2(CHANNELS + 1) + 1;

	localparam int MAP_LOW  = 1000;
	localparam int MAP_MID  = 1500;
	localparam int MAP_HIGH = 2000;
	localparam int MAP_SPAN = MAP_MID - MAP_LOW;

	localparam int RESET_LOWER  = 600;
	localparam int RESET_CENTER = 2000;
	localparam int RESET_UPPER  = 3000;
	localparam int OUT_MAX      = 4095;

	// numerator is a sample difference times the span
	localparam int NUM_BITS = SAMPLE_BITS + $clog2(MAP_SPAN);
	localparam int CNT_BITS = $clog2(NUM_BITS);
	localparam int SUM_BITS = NUM_BITS + 3;

	// register indexes on the configuration port
	localparam logic [CFG_IDX_BITS-1:0] REG_CAL_MODE = CFG_IDX_BITS'(CHANNELS);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOAD,
		ST_DIV,
		ST_HOLD
	} state_t;

	typedef struct packed {
		logic [NUM_BITS-1:0]    num;
		logic [SAMPLE_BITS-1:0] den;
		logic                   neg;
		logic                   upper;
	} prep_t;

	typedef struct packed {
		logic                   start;
		logic [NUM_BITS-1:0]    num;
		logic [SAMPLE_BITS-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic                done;
		logic [NUM_BITS-1:0] quot;
	} div_rsp_t;

endpackage

// ----- rtl/stick_calibrate_and_map_top.sv -----
// Stick calibrate and map: one scan of four stick samples in, four mapped values out.
// A scan is taken only when the block is idle, and the next scan is not taken until
// the result of the last has been handed to the output register. The work is done by
// the single bit-serial divider, which the four channels use in turn: per channel a
// set-up state, the division for the quotient bits and a write-back of the mapped value.
// The output register holds a finished result while the next scan is already being
// worked on. In calibration mode, bounds and centres are updated as each channel is mapped,
// after the mapping has used their previous values; configuration writes are meant
// for the idle block.
module stick_calibrate_and_map_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [scmap_pkg::CFG_IDX_BITS-1:0]   cfg_idx,
	input  logic [scmap_pkg::TRIM_BITS-1:0]      cfg_wdata,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [scmap_pkg::SAMPLE_BITS-1:0]    sample_ch0,
	input  logic [scmap_pkg::SAMPLE_BITS-1:0]    sample_ch1,
	input  logic [scmap_pkg::SAMPLE_BITS-1:0]    sample_ch2,
	input  logic [scmap_pkg::SAMPLE_BITS-1:0]    sample_ch3,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [scmap_pkg::OUT_BITS-1:0]       out_ch0,
	output logic [scmap_pkg::OUT_BITS-1:0]       out_ch1,
	output logic [scmap_pkg::OUT_BITS-1:0]       out_ch2,
	output logic [scmap_pkg::OUT_BITS-1:0]       out_ch3
);

	scmap_pkg::state_t state_q;
	scmap_pkg::state_t state_d;

	logic [scmap_pkg::CH_BITS-1:0]            ch_q;
	logic [scmap_pkg::SAMPLE_BITS-1:0]        samp_q [scmap_pkg::CHANNELS];
	logic [scmap_pkg::SAMPLE_BITS-1:0]        samp_in [scmap_pkg::CHANNELS];
	logic [scmap_pkg::SAMPLE_BITS-1:0]        lo_q [scmap_pkg::CHANNELS];
	logic [scmap_pkg::SAMPLE_BITS-1:0]        mid_q [scmap_pkg::CHANNELS];
	logic [scmap_pkg::SAMPLE_BITS-1:0]        hi_q [scmap_pkg::CHANNELS];
	logic signed [scmap_pkg::TRIM_BITS-1:0]   trim_q [scmap_pkg::CHANNELS];
	logic [scmap_pkg::OUT_BITS-1:0]           res_q [scmap_pkg::CHANNELS];
	logic [scmap_pkg::OUT_BITS-1:0]           out_q [scmap_pkg::CHANNELS];
	logic                                     cal_q;
	logic                                     capt_q;
	logic                                     neg_q;
	logic                                     upper_q;
	logic                                     out_valid_q;

	scmap_pkg::prep_t    prep;
	scmap_pkg::div_req_t div_req;
	scmap_pkg::div_rsp_t div_rsp;

	logic                                     in_acc;
	logic                                     out_free;
	logic                                     last_ch;
	logic                                     load_ch;
	logic                                     chan_done;
	logic                                     out_load;
	logic [scmap_pkg::SAMPLE_BITS-1:0]        cur;

	logic signed [scmap_pkg::SUM_BITS-1:0]    q_ext;
	logic signed [scmap_pkg::SUM_BITS-1:0]    trim_ext;
	logic signed [scmap_pkg::SUM_BITS-1:0]    base;
	logic signed [scmap_pkg::SUM_BITS-1:0]    sum;
	logic [scmap_pkg::OUT_BITS-1:0]           sat;

	assign samp_in[0] = sample_ch0;
	assign samp_in[1] = sample_ch1;
	assign samp_in[2] = sample_ch2;
	assign samp_in[3] = sample_ch3;

	assign cur      = samp_q[0];
	assign in_stall = (state_q != scmap_pkg::ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign last_ch  = (ch_q == scmap_pkg::CH_BITS'(scmap_pkg::CHANNELS - 1));

	scmap_prep u_prep (
		.sample (cur),
		.lo     (lo_q[ch_q]),
		.mid    (mid_q[ch_q]),
		.hi     (hi_q[ch_q]),
		.prep   (prep)
	);

	assign div_req.start = load_ch;
	assign div_req.num   = prep.num;
	assign div_req.den   = prep.den;

	scmap_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// sequencer
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			scmap_pkg::ST_IDLE: begin
				if (in_acc) begin
					state_d = scmap_pkg::ST_LOAD;
				end
			end
			scmap_pkg::ST_LOAD: begin
				state_d = scmap_pkg::ST_DIV;
			end
			scmap_pkg::ST_DIV: begin
				if (div_rsp.done) begin
					state_d = last_ch ? scmap_pkg::ST_HOLD : scmap_pkg::ST_LOAD;
				end
			end
			scmap_pkg::ST_HOLD: begin
				if (out_free) begin
					state_d = scmap_pkg::ST_IDLE;
				end
			end
			default: state_d = scmap_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		load_ch   = 1'b0;
		chan_done = 1'b0;
		out_load  = 1'b0;
		unique case (state_q)
			scmap_pkg::ST_IDLE: ;
			scmap_pkg::ST_LOAD: load_ch = 1'b1;
			scmap_pkg::ST_DIV:  chan_done = div_rsp.done;
			scmap_pkg::ST_HOLD: out_load = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= scmap_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// base plus signed quotient plus trim, saturated to the output range
	always_comb begin
		q_ext    = scmap_pkg::SUM_BITS'(div_rsp.quot);
		trim_ext = {{(scmap_pkg::SUM_BITS - scmap_pkg::TRIM_BITS){trim_q[ch_q][
			scmap_pkg::TRIM_BITS-1]}}, trim_q[ch_q]};
		base     = upper_q ? scmap_pkg::SUM_BITS'(scmap_pkg::MAP_MID) :
			scmap_pkg::SUM_BITS'(scmap_pkg::MAP_LOW);
		sum      = base + (neg_q ? -q_ext : q_ext) + trim_ext;
		if (sum[scmap_pkg::SUM_BITS-1]) begin
			sat = '0;
		end else if (sum > scmap_pkg::SUM_BITS'(scmap_pkg::OUT_MAX)) begin
			sat = scmap_pkg::OUT_BITS'(scmap_pkg::OUT_MAX);
		end else begin
			sat = sum[scmap_pkg::OUT_BITS-1:0];
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < scmap_pkg::CHANNELS; i++) begin
				trim_q[i] <= '0;
			end
			cal_q <= 1'b0;
		end else if (cfg_we) begin
			if (cfg_idx < scmap_pkg::REG_CAL_MODE) begin
				trim_q[cfg_idx[scmap_pkg::CH_BITS-1:0]] <= cfg_wdata;
			end else if (cfg_idx == scmap_pkg::REG_CAL_MODE) begin
				cal_q <= cfg_wdata[0];
			end
		end
	end

	// calibration state, updated in calibration mode, one channel per set-up cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < scmap_pkg::CHANNELS; i++) begin
				lo_q[i]  <= scmap_pkg::SAMPLE_BITS'(scmap_pkg::RESET_LOWER);
				mid_q[i] <= scmap_pkg::SAMPLE_BITS'(scmap_pkg::RESET_CENTER);
				hi_q[i]  <= scmap_pkg::SAMPLE_BITS'(scmap_pkg::RESET_UPPER);
			end
			capt_q <= 1'b0;
		end else begin
			if (load_ch && cal_q) begin
				if (!capt_q) begin
					mid_q[ch_q] <= cur;
				end else begin
					if (cur > hi_q[ch_q]) begin
						hi_q[ch_q] <= cur;
					end
					if (cur < lo_q[ch_q]) begin
						lo_q[ch_q] <= cur;
					end
				end
			end
			if (chan_done && last_ch) begin
				capt_q <= cal_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ch_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_acc) begin
				ch_q <= '0;
			end else if (chan_done) begin
				ch_q <= ch_q + 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// sample and result shift lines move one channel per completed division
	always_ff @(posedge clk) begin
		if (in_acc) begin
			for (int i = 0; i < scmap_pkg::CHANNELS; i++) begin
				samp_q[i] <= samp_in[i];
			end
		end else if (chan_done) begin
			for (int i = 0; i < scmap_pkg::CHANNELS - 1; i++) begin
				samp_q[i] <= samp_q[i+1];
			end
		end
		if (chan_done) begin
			for (int i = 0; i < scmap_pkg::CHANNELS - 1; i++) begin
				res_q[i] <= res_q[i+1];
			end
			res_q[scmap_pkg::CHANNELS-1] <= sat;
		end
		if (load_ch) begin
			neg_q   <= prep.neg;
			upper_q <= prep.upper;
		end
		if (out_load) begin
			for (int i = 0; i < scmap_pkg::CHANNELS; i++) begin
				out_q[i] <= res_q[i];
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_ch0   = out_q[0];
	assign out_ch1   = out_q[1];
	assign out_ch2   = out_q[2];
	assign out_ch3   = out_q[3];

endmodule

// ----- rtl/scmap_prep.sv -----
// clamp of one sample and set-up of the numerator and divisor for its segment
module scmap_prep (
	input  logic [scmap_pkg::SAMPLE_BITS-1:0] sample,
	input  logic [scmap_pkg::SAMPLE_BITS-1:0] lo,
	input  logic [scmap_pkg::SAMPLE_BITS-1:0] mid,
	input  logic [scmap_pkg::SAMPLE_BITS-1:0] hi,
	output scmap_pkg::prep_t                  prep
);

	logic [scmap_pkg::SAMPLE_BITS-1:0] v_hi;
	logic [scmap_pkg::SAMPLE_BITS-1:0] v_cl;
	logic [scmap_pkg::SAMPLE_BITS-1:0] diff;
	logic [scmap_pkg::SAMPLE_BITS:0]   hd;
	logic                              lower_half;
	logic                              flat;

	always_comb begin
		// upper clamp first, then lower, so inverted bounds end on lo
		v_hi       = (sample > hi) ? hi : sample;
		v_cl       = (v_hi < lo) ? lo : v_hi;
		lower_half = (v_cl < mid);
		flat       = !lower_half && (hi == mid);
		hd         = {1'b0, hi} - {1'b0, mid};
		diff       = lower_half ? (v_cl - lo) : (v_cl - mid);

		prep.upper = !lower_half;
		prep.num   = scmap_pkg::NUM_BITS'(diff) *
			scmap_pkg::NUM_BITS'(scmap_pkg::MAP_SPAN);
		if (lower_half) begin
			prep.den = mid - lo;
			prep.neg = 1'b0;
		end else if (flat) begin
			// flat upper half: zero over one gives the centre value
			prep.num = '0;
			prep.den = scmap_pkg::SAMPLE_BITS'(1);
			prep.neg = 1'b0;
		end else begin
			prep.neg = hd[scmap_pkg::SAMPLE_BITS];
			prep.den = hd[scmap_pkg::SAMPLE_BITS] ?
				scmap_pkg::SAMPLE_BITS'(-hd) : hd[scmap_pkg::SAMPLE_BITS-1:0];
		end
	end

endmodule

// ----- rtl/scmap_div.sv -----
// bit-serial restoring divider, one quotient bit per cycle
module scmap_div (
	input  logic                clk,
	input  logic                arst_n,
	input  scmap_pkg::div_req_t req,
	output scmap_pkg::div_rsp_t rsp
);

	logic [scmap_pkg::NUM_BITS-1:0]    dvd_q;
	logic [scmap_pkg::SAMPLE_BITS-1:0] rem_q;
	logic [scmap_pkg::SAMPLE_BITS-1:0] den_q;
	logic [scmap_pkg::CNT_BITS-1:0]    cnt_q;
	logic                              busy_q;
	logic                              done_q;

	logic [scmap_pkg::SAMPLE_BITS:0]   trial;
	logic                              ge;
	logic [scmap_pkg::SAMPLE_BITS:0]   diff;

	always_comb begin
		trial = {rem_q, dvd_q[scmap_pkg::NUM_BITS-1]};
		ge    = (trial >= {1'b0, den_q});
		diff  = trial - {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == '0);
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= scmap_pkg::CNT_BITS'(scmap_pkg::NUM_BITS - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// quotient bits shift in behind the dividend bits
	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.num;
			den_q <= req.den;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[scmap_pkg::NUM_BITS-2:0], ge};
			rem_q <= ge ? diff[scmap_pkg::SAMPLE_BITS-1:0] :
				trial[scmap_pkg::SAMPLE_BITS-1:0];
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = dvd_q;

endmodule

// ----- rtl/scmap_checker.sv -----
// port-level checks for the stick calibrate and map block, bound to the top level
module scmap_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               in_valid,
	input logic                               in_stall,
	input logic                               out_valid,
	input logic                               out_stall,
	input logic [scmap_pkg::OUT_BITS-1:0]     out_ch0,
	input logic [scmap_pkg::OUT_BITS-1:0]     out_ch1,
	input logic [scmap_pkg::OUT_BITS-1:0]     out_ch2,
	input logic [scmap_pkg::OUT_BITS-1:0]     out_ch3
);

	// an accepted scan keeps the input side stalled while it is worked on
	a_busy_after_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input not stalled after an accepted beat");

	// the block only goes idle by handing over a result
	a_idle_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(in_stall) |-> out_valid)
		else $error("input side freed without a result");

	a_result_at_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $fell(in_stall))
		else $error("result shown while the block stays busy");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(out_ch0) && $stable(out_ch1)
			&& $stable(out_ch2) && $stable(out_ch3)))
		else $error("stalled output beat changed");

endmodule

bind stick_calibrate_and_map_top scmap_checker u_scmap_checker (.*);
